// ----- design/dlsgd_pkg.sv -----
// Shared types, sizes and helpers for the dense layer training engine.
// Used by the controller, the datapath, the top level and the checker.
package dlsgd_pkg;

    localparam int IN_SIZE    = 16;
    localparam int OUT_SIZE   = 16;
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int DELTA_W    = 40;
    localparam int LR_W       = 16;

    localparam int IW    = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
    localparam int JW    = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
    localparam int ELEMS = IN_SIZE * OUT_SIZE;
    localparam int AW    = (ELEMS > 1) ? $clog2(ELEMS) : 1;

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int MAXDIM = (IN_SIZE > OUT_SIZE) ? IN_SIZE : OUT_SIZE;
    localparam int ACC_W  = PROD_W + ((MAXDIM > 1) ? $clog2(MAXDIM) : 1) + 1;
    localparam int SAT_W  = 48;

    localparam logic signed [SAT_W-1:0] DATA_MAX =
        SAT_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SAT_W-1:0] DATA_MIN =
        SAT_W'(-(64'sd1 <<< (DATA_WIDTH - 1)));

    localparam logic [2:0] ACT_WRITE    = 3'd0;
    localparam logic [2:0] ACT_LOAD_ACT = 3'd1;
    localparam logic [2:0] ACT_LOAD_DER = 3'd2;
    localparam logic [2:0] ACT_FORWARD  = 3'd3;
    localparam logic [2:0] ACT_BACKWARD = 3'd4;
    localparam logic [2:0] ACT_COMMIT   = 3'd5;
    localparam logic [2:0] ACT_READ     = 3'd6;

    localparam logic [1:0] KIND_FWD  = 2'd0;
    localparam logic [1:0] KIND_GRAD = 2'd1;
    localparam logic [1:0] KIND_RDW  = 2'd2;
    localparam logic [1:0] KIND_CMT  = 2'd3;

    typedef enum logic [2:0] {
        OP_CLR,
        OP_WR,
        OP_RD,
        OP_FWD,
        OP_BWD,
        OP_CMT
    } op_t;

    typedef struct packed {
        logic                         valid;
        op_t                          op;
        logic [IW-1:0]                i;
        logic [JW-1:0]                j;
        logic signed [DATA_WIDTH-1:0] wdata;
        logic                         inrange;
        logic                         first;
        logic                         glast;
        logic                         last;
        logic                         ld_act;
        logic                         ld_der;
    } cmd_t;

    typedef struct packed {
        logic adv;
        logic busy;
    } sts_t;

    typedef struct packed {
        logic                         clip;
        logic signed [DATA_WIDTH-1:0] val;
    } sat_t;

    function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] i, input logic [JW-1:0] j);
        return AW'(i) * AW'(OUT_SIZE) + AW'(j);
    endfunction

    function automatic sat_t sat_data(input logic signed [SAT_W-1:0] x);
        sat_t r;
        r.clip = 1'b0;
        r.val  = x[DATA_WIDTH-1:0];
        if (x > DATA_MAX)
        begin
            r.clip = 1'b1;
            r.val  = DATA_MAX[DATA_WIDTH-1:0];
        end
        else if (x < DATA_MIN)
        begin
            r.clip = 1'b1;
            r.val  = DATA_MIN[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/dlsgd_ctrl.sv -----
// Controller of the dense layer training engine: decodes input words and walks
// the weight matrix, issuing one element command per cycle while the datapath advances. Depends on dlsgd_pkg.
module dlsgd_ctrl import dlsgd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   action,
    input  logic [3:0]                   row,
    input  logic [3:0]                   col,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  sts_t                         sts,
    output cmd_t                         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    op_t           op_reg, op_next;
    logic [IW-1:0] i_reg, i_next;
    logic [JW-1:0] j_reg, j_next;
    logic          i_last, j_last, accept, row_ok, col_ok;

    assign i_last   = (i_reg == IW'(IN_SIZE - 1));
    assign j_last   = (j_reg == JW'(OUT_SIZE - 1));
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign row_ok   = (int'(row) < IN_SIZE);
    assign col_ok   = (int'(col) < OUT_SIZE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd        = '0;
        cmd.op     = OP_CLR;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.i     = IW'(row);
                cmd.j     = JW'(col);
                cmd.wdata = value;
                if (accept)
                begin
                    unique case (action)
                        ACT_WRITE, ACT_READ:
                        begin
                            cmd.valid   = 1'b1;
                            cmd.op      = (action == ACT_WRITE) ? OP_WR : OP_RD;
                            cmd.inrange = row_ok && col_ok;
                            cmd.first   = 1'b1;
                            cmd.glast   = 1'b1;
                            cmd.last    = 1'b1;
                            state_next  = ST_DRAIN;
                        end
                        ACT_LOAD_ACT: cmd.ld_act = row_ok;
                        ACT_LOAD_DER: cmd.ld_der = col_ok;
                        ACT_FORWARD, ACT_BACKWARD, ACT_COMMIT:
                        begin
                            op_next    = (action == ACT_FORWARD)  ? OP_FWD :
                                         (action == ACT_BACKWARD) ? OP_BWD : OP_CMT;
                            i_next     = '0;
                            j_next     = '0;
                            state_next = ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                cmd.valid   = 1'b1;
                cmd.op      = op_reg;
                cmd.i       = i_reg;
                cmd.j       = j_reg;
                cmd.inrange = 1'b1;
                cmd.last    = i_last && j_last;
                if (op_reg == OP_FWD)
                begin
                    cmd.first = (i_reg == '0);
                    cmd.glast = i_last;
                end
                else if (op_reg == OP_BWD)
                begin
                    cmd.first = (j_reg == '0);
                    cmd.glast = j_last;
                end
                else
                begin
                    cmd.first = (i_reg == '0) && (j_reg == '0);
                    cmd.glast = i_last && j_last;
                end
                if (sts.adv)
                begin
                    // Forward runs down a column; the others run along a row.
                    if (op_reg == OP_FWD)
                    begin
                        i_next = i_last ? '0 : i_reg + IW'(1);
                        if (i_last)
                            j_next = j_reg + JW'(1);
                    end
                    else
                    begin
                        j_next = j_last ? '0 : j_reg + JW'(1);
                        if (j_last)
                            i_next = i_reg + IW'(1);
                    end
                    if (i_last && j_last)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.busy)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Reset starts a clearing sweep over both matrix memories.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            op_reg    <= OP_CLR;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

endmodule

// ----- design/dlsgd_dp.sv -----
// Datapath of the dense layer training engine: weight and delta memories,
// vector buffers, the multiply pipeline, accumulator and result register.
// Depends on dlsgd_pkg; driven by dlsgd_ctrl commands.
module dlsgd_dp import dlsgd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmd_t                         cmd,
    output sts_t                         sts,
    input  logic                         cfg_valid,
    input  logic [LR_W-1:0]              cfg_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   kind,
    output logic [3:0]                   index,
    output logic signed [DATA_WIDTH-1:0] value_res,
    output logic                         saturated,
    output logic                         last
);

    localparam int DLO_W     = DELTA_W / 2;
    localparam int DHI_W     = DELTA_W - DLO_W;
    localparam int LO_W      = LR_W + DLO_W;
    localparam int HI_W      = LR_W + 1 + DHI_W;
    localparam int PW        = LR_W + DELTA_W + 1;
    localparam int CMT_SHIFT = LR_W + FRAC_BITS;
    localparam int STEP_W    = PW - CMT_SHIFT;
    localparam int WD_W      = STEP_W + 1;
    localparam int DS_W      = DELTA_W + 1;
    localparam logic signed [PW-1:0]    CMT_HALF  = PW'(1) <<< (CMT_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] ACC_HALF  = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [DS_W-1:0]  DELTA_MAX = DS_W'((64'sd1 <<< (DELTA_W - 1)) - 64'sd1);
    localparam logic signed [DS_W-1:0]  DELTA_MIN = DS_W'(-(64'sd1 <<< (DELTA_W - 1)));

    logic signed [DATA_WIDTH-1:0] wmem [ELEMS];
    logic signed [DELTA_W-1:0]    dmem [ELEMS];
    logic signed [DATA_WIDTH-1:0] act_reg [IN_SIZE];
    logic signed [DATA_WIDTH-1:0] der_reg [OUT_SIZE];
    logic [LR_W-1:0]              lr_reg;

    cmd_t                         s1_cmd_reg, s2_cmd_reg;
    logic signed [DATA_WIDTH-1:0] w1_reg, a1_reg, g1_reg, w2_reg;
    logic signed [DELTA_W-1:0]    d1_reg, d2_reg;
    logic signed [PROD_W-1:0]     p1_reg, p2_reg;
    logic [LO_W-1:0]              lo_reg;
    logic signed [HI_W-1:0]       hi_reg;
    logic signed [ACC_W-1:0]      acc_reg, acc_next, rnd;
    logic                         any_reg, any_next;

    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   kind_reg, kind_next;
    logic [3:0]                   index_reg, index_next;
    logic signed [DATA_WIDTH-1:0] val_reg, val_next;
    logic                         sat_reg, sat_next, last_reg, last_next;

    logic signed [DATA_WIDTH-1:0] mul_a;
    logic signed [PW-1:0]         p_full, p_rnd;
    logic signed [STEP_W-1:0]     step;
    logic signed [WD_W-1:0]       wdiff;
    logic signed [DS_W-1:0]       dsum;
    logic signed [DELTA_W-1:0]    dsat;
    sat_t                         ysat, wsat;
    logic                         emit, adv, s2v;
    logic                         wmem_we, dmem_we;
    logic signed [DATA_WIDTH-1:0] wmem_wd;
    logic signed [DELTA_W-1:0]    dmem_wd;
    logic [AW-1:0]                rd_addr, wr_addr;

    assign rd_addr = addr_of(cmd.i, cmd.j);
    assign wr_addr = addr_of(s2_cmd_reg.i, s2_cmd_reg.j);
    assign s2v     = s2_cmd_reg.valid;

    // Result of the final stage; the whole pipeline holds while it cannot leave.
    assign emit = s2v && (((s2_cmd_reg.op == OP_FWD || s2_cmd_reg.op == OP_BWD) &&
                           s2_cmd_reg.glast) ||
                          (s2_cmd_reg.op == OP_CMT && s2_cmd_reg.last) ||
                          s2_cmd_reg.op == OP_RD);
    assign adv  = !(emit && out_valid_reg && out_stall);
    assign sts.adv  = adv;
    assign sts.busy = s1_cmd_reg.valid || s2v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lr_reg <= LR_W'(655);
        else if (cfg_valid)
            lr_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < IN_SIZE; k++)
                act_reg[k] <= '0;
            for (int k = 0; k < OUT_SIZE; k++)
                der_reg[k] <= '0;
        end
        else
        begin
            if (cmd.ld_act)
                act_reg[cmd.i] <= cmd.wdata;
            if (cmd.ld_der)
                der_reg[cmd.j] <= cmd.wdata;
        end
    end

    // Stage one: memory and buffer reads.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w1_reg <= wmem[rd_addr];
            d1_reg <= dmem[rd_addr];
            a1_reg <= act_reg[cmd.i];
            g1_reg <= der_reg[cmd.j];
        end
    end

    // Stage two: products. The commit product is split into two halves of the delta.
    assign mul_a = (s1_cmd_reg.op == OP_FWD) ? a1_reg : g1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= mul_a * w1_reg;
            p2_reg <= a1_reg * g1_reg;
            lo_reg <= lr_reg * d1_reg[DLO_W-1:0];
            hi_reg <= $signed({1'b0, lr_reg}) * $signed(d1_reg[DELTA_W-1:DLO_W]);
            w2_reg <= w1_reg;
            d2_reg <= d1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_cmd_reg <= '0;
            s2_cmd_reg <= '0;
        end
        else if (adv)
        begin
            s1_cmd_reg <= cmd;
            s2_cmd_reg <= s1_cmd_reg;
        end
    end

    // Stage three: accumulate, update the matrices and form the result.
    always_comb
    begin
        acc_next = s2_cmd_reg.first ? ACC_W'(p1_reg) : acc_reg + ACC_W'(p1_reg);
        rnd      = (acc_next + ACC_HALF) >>> FRAC_BITS;
        ysat     = sat_data(SAT_W'(rnd));

        p_full = (PW'(hi_reg) <<< DLO_W) + PW'($signed({1'b0, lo_reg}));
        p_rnd  = p_full + CMT_HALF;
        step   = p_rnd[PW-1:CMT_SHIFT];
        wdiff  = WD_W'(w2_reg) - WD_W'(step);
        wsat   = sat_data(SAT_W'(wdiff));
        any_next = (s2_cmd_reg.first ? 1'b0 : any_reg) | wsat.clip;

        dsum = DS_W'(d2_reg) + DS_W'(p2_reg);
        if (dsum > DELTA_MAX)
            dsat = DELTA_MAX[DELTA_W-1:0];
        else if (dsum < DELTA_MIN)
            dsat = DELTA_MIN[DELTA_W-1:0];
        else
            dsat = dsum[DELTA_W-1:0];

        wmem_we = 1'b0;
        dmem_we = 1'b0;
        wmem_wd = '0;
        dmem_wd = '0;
        kind_next  = KIND_FWD;
        index_next = 4'(s2_cmd_reg.j);
        val_next   = ysat.val;
        sat_next   = ysat.clip;
        last_next  = s2_cmd_reg.last;
        unique case (s2_cmd_reg.op)
            OP_CLR:
            begin
                wmem_we = s2v;
                dmem_we = s2v;
            end
            OP_WR:
            begin
                wmem_we = s2v && s2_cmd_reg.inrange;
                wmem_wd = s2_cmd_reg.wdata;
            end
            OP_RD:
            begin
                kind_next = KIND_RDW;
                val_next  = s2_cmd_reg.inrange ? w2_reg : '0;
                sat_next  = 1'b0;
            end
            OP_FWD: ;
            OP_BWD:
            begin
                dmem_we    = s2v;
                dmem_wd    = dsat;
                kind_next  = KIND_GRAD;
                index_next = 4'(s2_cmd_reg.i);
            end
            OP_CMT:
            begin
                wmem_we    = s2v;
                wmem_wd    = wsat.val;
                dmem_we    = s2v;
                kind_next  = KIND_CMT;
                index_next = '0;
                val_next   = '0;
                sat_next   = any_next;
            end
            default: ;
        endcase

        if (adv && emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && wmem_we)
            wmem[wr_addr] <= wmem_wd;
    end

    always_ff @(posedge clk)
    begin
        if (adv && dmem_we)
            dmem[wr_addr] <= dmem_wd;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2v)
        begin
            acc_reg <= acc_next;
            any_reg <= any_next;
        end
        if (adv && emit)
        begin
            kind_reg  <= kind_next;
            index_reg <= index_next;
            val_reg   <= val_next;
            sat_reg   <= sat_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign index     = index_reg;
    assign value_res = val_reg;
    assign saturated = sat_reg;
    assign last      = last_reg;

endmodule

// ----- design/dense_layer_sgd_engine.sv -----
// Top level of the dense layer training engine.
// Instantiates dlsgd_ctrl and dlsgd_dp; depends on dlsgd_pkg.
//
// Input words carry an action with row, col and value. Weight writes and the
// two vector loads produce nothing; a weight read produces one result word;
// forward produces OUT_SIZE words (kind 0), backward IN_SIZE words (kind 1),
// commit one word (kind 3) whose saturated bit tells whether any weight clipped.
// The last bit marks the final word of each operation.
// The learning rate is written on the cfg channel, which is always ready; it
// must only be written while the block is idle.
// Pipeline: a single multiply-accumulate pipeline visits one matrix element per
// cycle while the output is not stalled. A result passes the read, product
// and accumulate stages and the output register before it leaves.
// Reset: the weight and delta memories are cleared by a sweep over every
// element, during which in_stall stays high.
// When the receiver stalls, the finished word is held in the output register;
// the pipeline freezes once another word is ready to leave, until the held word is
// taken. A new input is taken while the last word of an operation still waits.
module dense_layer_sgd_engine import dlsgd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   action,
    input  logic [3:0]                   row,
    input  logic [3:0]                   col,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [LR_W-1:0]              cfg_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   kind,
    output logic [3:0]                   index,
    output logic signed [DATA_WIDTH-1:0] value_res,
    output logic                         saturated,
    output logic                         last
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    dlsgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .row      (row),
        .col      (col),
        .value    (value),
        .sts      (sts),
        .cmd      (cmd)
    );

    dlsgd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .index     (index),
        .value_res (value_res),
        .saturated (saturated),
        .last      (last)
    );

endmodule

// ----- design/dlsgd_checker.sv -----
// Port-level assertions for the dense layer training engine, and the bind
// that attaches them to the top level. Depends on dlsgd_pkg.
module dlsgd_checker import dlsgd_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [1:0]                   kind,
    input logic [3:0]                   index,
    input logic signed [DATA_WIDTH-1:0] value_res,
    input logic                         saturated,
    input logic                         last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value_res) && $stable(kind))
        else $error("stalled result word changed");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall)
        else $error("input accepted during the clearing sweep");

    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_CMT |-> last && index == 4'd0 && value_res == '0)
        else $error("malformed commit word");

    a_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_RDW |-> last && !saturated)
        else $error("malformed weight read word");

endmodule

bind dense_layer_sgd_engine dlsgd_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .index     (index),
    .value_res (value_res),
    .saturated (saturated),
    .last      (last)
);
